// ===== rtl/tel_pkg.sv =====
package tel_pkg;

  localparam int STICK_W = 11;
  localparam int RATE_W  = 16;
  localparam int TIME_W  = 32;

  localparam int STICK_THR_W = 10;
  localparam int RATE_THR_W  = 15;
  localparam int HOLD_W      = 24;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [STICK_THR_W-1:0] STICK_THR_RST = STICK_THR_W'(100);
  localparam logic [RATE_THR_W-1:0]  RATE_THR_RST  = RATE_THR_W'(150);
  localparam logic [HOLD_W-1:0]      HOLD_RST      = HOLD_W'(250000);

  // register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_STICK_THR = 2'd0,
    REG_RATE_THR  = 2'd1,
    REG_HOLD_TIME = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] roll_stick;
    logic signed [STICK_W-1:0] pitch_stick;
    logic signed [RATE_W-1:0]  roll_rate;
    logic signed [RATE_W-1:0]  pitch_rate;
    logic [TIME_W-1:0]         now_us;
    logic                      armed;
    logic                      rescue_active;
    logic                      link_ok;
  } in_item_t;

endpackage

// ===== rtl/tel_if.sv =====
interface tel_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tel_pkg::STICK_W-1:0]  roll_stick;
  logic signed [tel_pkg::STICK_W-1:0]  pitch_stick;
  logic signed [tel_pkg::RATE_W-1:0]   roll_rate;
  logic signed [tel_pkg::RATE_W-1:0]   pitch_rate;
  logic [tel_pkg::TIME_W-1:0]          now_us;
  logic                                armed;
  logic                                rescue_active;
  logic                                link_ok;

  modport source (
    output valid, roll_stick, pitch_stick, roll_rate, pitch_rate, now_us,
           armed, rescue_active, link_ok,
    input  ready
  );
  modport sink (
    input  valid, roll_stick, pitch_stick, roll_rate, pitch_rate, now_us,
           armed, rescue_active, link_ok,
    output ready
  );
endinterface

interface tel_out_if;
  logic valid;
  logic ready;
  logic is_airborne;
  logic evidence_now;

  modport source (output valid, is_airborne, evidence_now, input ready);
  modport sink (input valid, is_airborne, evidence_now, output ready);
endinterface

// ===== rtl/takeoff_evidence_latch_unit.sv =====
// Takeoff evidence latch.
// in_ch (valid/ready): one control tick per transfer - roll/pitch stick,
//   roll/pitch gyro rate, microsecond timestamp and arm, rescue and link flags.
// out_ch (valid/ready): one result per tick - latched is_airborne and
//   evidence_now for that tick, in tick order.
// cfg_*: APB-style write/read port; stick_threshold at 0x0, rate_threshold
//   at 0x4, hold_time_us at 0x8. pready is tied high. Write only while idle.
// Throughput: one tick per cycle while out_ch is not stalled. A tick passes
//   through an input register into the result register, which drives out_ch valid.
//   An input register, then the per-axis compare, the 32-bit elapsed-time
//   subtract and the state update feed the result register.
// The flight and per-axis state advance when a tick moves from the input
//   register into the result register, so back-to-back ticks each see the
//   state left by the one before.
// Stall: if out_ch.ready is low the result register holds, the input register
//   can still fill, and in_ch.ready drops only when both are occupied.
// Reset (rst_n low, synchronous): both stages empty, landed, axes cleared,
//   thresholds back to 100 / 150 / 250000.
module takeoff_evidence_latch_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  tel_in_if.sink                              in_ch,
  tel_out_if.source                           out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tel_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [tel_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [tel_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import tel_pkg::*;

  // configuration registers
  logic [STICK_THR_W-1:0] stick_thr_r;
  logic [RATE_THR_W-1:0]  rate_thr_r;
  logic [HOLD_W-1:0]      hold_r;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  // pipeline
  logic     s1_v_r, s1_v_nxt;
  in_item_t s1_item_r;
  logic     out_v_r, out_v_nxt;
  logic     out_air_r, out_ev_r;
  logic     adv, s1_fire, in_fire;

  // block state
  logic              flying_r, flying_nxt;
  dir_t              axis_dir_r   [2];
  dir_t              axis_dir_nxt [2];
  logic [TIME_W-1:0] axis_since_r   [2];
  logic [TIME_W-1:0] axis_since_nxt [2];

  // per-axis evaluation
  logic signed [STICK_W-1:0] stick [2];
  logic signed [RATE_W-1:0]  rate  [2];
  logic [STICK_W-1:0]        mag   [2];
  logic                      pos   [2];
  logic signed [RATE_W:0]    rate_x [2];
  logic signed [RATE_W:0]    along [2];
  dir_t                      dir_new [2];
  logic                      match [2];
  logic [TIME_W-1:0]         since_eff [2];
  logic [TIME_W-1:0]         elapsed [2];
  logic                      hold_ok [2];
  logic                      evidence;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_STICK_THR: cfg_prdata = CFG_DATA_W'(stick_thr_r);
      REG_RATE_THR:  cfg_prdata = CFG_DATA_W'(rate_thr_r);
      REG_HOLD_TIME: cfg_prdata = CFG_DATA_W'(hold_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_thr_r <= STICK_THR_RST;
      rate_thr_r  <= RATE_THR_RST;
      hold_r      <= HOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STICK_THR: stick_thr_r <= cfg_pwdata[STICK_THR_W-1:0];
        REG_RATE_THR:  rate_thr_r  <= cfg_pwdata[RATE_THR_W-1:0];
        REG_HOLD_TIME: hold_r      <= cfg_pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign adv         = !out_v_r || out_ch.ready;
  assign s1_fire     = s1_v_r && adv;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_v_nxt    = in_fire || (s1_v_r && !adv);
  assign out_v_nxt   = s1_fire || (out_v_r && !out_ch.ready);

  assign out_ch.valid        = out_v_r;
  assign out_ch.is_airborne  = out_air_r;
  assign out_ch.evidence_now = out_ev_r;

  // ---------------- per-axis check ----------------
  always_comb begin
    stick[0] = s1_item_r.roll_stick;
    stick[1] = s1_item_r.pitch_stick;
    rate[0]  = s1_item_r.roll_rate;
    rate[1]  = s1_item_r.pitch_rate;
    for (int a = 0; a < 2; a++) begin
      // zero stick counts as negative
      pos[a]     = !stick[a][STICK_W-1] && (stick[a] != '0);
      // -(-1024) = 1024 fits unsigned in 11 bits
      mag[a]     = stick[a][STICK_W-1] ? STICK_W'(-stick[a]) : STICK_W'(stick[a]);
      rate_x[a]  = {rate[a][RATE_W-1], rate[a]};
      along[a]   = pos[a] ? rate_x[a] : -rate_x[a];
      dir_new[a] = pos[a] ? DIR_POS : DIR_NEG;
      match[a]   = (mag[a] >= {1'b0, stick_thr_r}) &&
                   (along[a] >= $signed({2'b00, rate_thr_r}));
      // direction change restarts the timer at now
      since_eff[a] = (axis_dir_r[a] != dir_new[a]) ? s1_item_r.now_us
                                                   : axis_since_r[a];
      elapsed[a]   = s1_item_r.now_us - since_eff[a];
      hold_ok[a]   = elapsed[a] >= {{(TIME_W-HOLD_W){1'b0}}, hold_r};
    end
  end

  // ---------------- state update ----------------
  always_comb begin
    flying_nxt = flying_r;
    evidence   = 1'b0;
    for (int a = 0; a < 2; a++) begin
      axis_dir_nxt[a]   = axis_dir_r[a];
      axis_since_nxt[a] = axis_since_r[a];
    end
    if (!s1_item_r.armed) begin
      flying_nxt = 1'b0;
      for (int a = 0; a < 2; a++) begin
        axis_dir_nxt[a]   = DIR_NONE;
        axis_since_nxt[a] = '0;
      end
    end else if (!flying_r) begin
      if (s1_item_r.rescue_active) begin
        evidence = 1'b1;
      end else if (s1_item_r.link_ok) begin
        for (int a = 0; a < 2; a++) begin
          if (match[a]) begin
            axis_dir_nxt[a]   = dir_new[a];
            axis_since_nxt[a] = since_eff[a];
            if (hold_ok[a]) evidence = 1'b1;
          end else begin
            axis_dir_nxt[a]   = DIR_NONE;
            axis_since_nxt[a] = '0;
          end
        end
      end else begin
        for (int a = 0; a < 2; a++) begin
          axis_dir_nxt[a]   = DIR_NONE;
          axis_since_nxt[a] = '0;
        end
      end
      if (evidence) begin
        flying_nxt = 1'b1;
        for (int a = 0; a < 2; a++) begin
          axis_dir_nxt[a]   = DIR_NONE;
          axis_since_nxt[a] = '0;
        end
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      flying_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        axis_dir_r[a]   <= DIR_NONE;
        axis_since_r[a] <= '0;
      end
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_fire) begin
        flying_r <= flying_nxt;
        for (int a = 0; a < 2; a++) begin
          axis_dir_r[a]   <= axis_dir_nxt[a];
          axis_since_r[a] <= axis_since_nxt[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.roll_stick    <= in_ch.roll_stick;
      s1_item_r.pitch_stick   <= in_ch.pitch_stick;
      s1_item_r.roll_rate     <= in_ch.roll_rate;
      s1_item_r.pitch_rate    <= in_ch.pitch_rate;
      s1_item_r.now_us        <= in_ch.now_us;
      s1_item_r.armed         <= in_ch.armed;
      s1_item_r.rescue_active <= in_ch.rescue_active;
      s1_item_r.link_ok       <= in_ch.link_ok;
    end
    if (s1_fire) begin
      out_air_r <= flying_nxt;
      out_ev_r  <= evidence;
    end
  end

`ifndef SYNTHESIS
  // once flying, both axes stay cleared until disarm
  a_fly_axes_clear: assert property (@(posedge clk) disable iff (!rst_n)
    flying_r |-> (axis_dir_r[0] == DIR_NONE && axis_dir_r[1] == DIR_NONE))
    else $error("axis state live while airborne");

  // an idle axis carries no start time
  a_idle_since_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (axis_dir_r[0] == DIR_NONE |-> axis_since_r[0] == '0) and
    (axis_dir_r[1] == DIR_NONE |-> axis_since_r[1] == '0))
    else $error("idle axis with nonzero start time");

  // a result with evidence always reports airborne
  a_ev_implies_air: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ev_r) |-> out_air_r)
    else $error("evidence without airborne");

  // takeoff latches only together with an evidence result
  a_rise_with_ev: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flying_r) |-> (out_v_r && out_ev_r && $past(s1_fire)))
    else $error("flight latched without evidence");

  // a held tick stays in the input register while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ch.ready) |=> s1_v_r)
    else $error("tick dropped under stall");
`endif

endmodule

// ===== sim/tb_takeoff_evidence_latch_unit.sv =====
import tel_pkg::*;

typedef struct packed {
  logic airborne;
  logic evidence;
} flight_verdict_t;

// Flight-state predictor plus expected-result queue
class airborne_scoreboard;
  logic [STICK_THR_W-1:0] stick_thr;
  logic [RATE_THR_W-1:0]  rate_thr;
  logic [HOLD_W-1:0]      hold_us;
  logic                   flying;
  dir_t                   axis_dir[2];
  logic [TIME_W-1:0]      axis_start[2];
  flight_verdict_t        expected_q[$];
  int unsigned            failures;

  function new();
    stick_thr = STICK_THR_RST;
    rate_thr  = RATE_THR_RST;
    hold_us   = HOLD_RST;
    flying    = 1'b0;
    failures  = 0;
    clear_axes();
  endfunction

  function void clear_axes();
    for (int a = 0; a < 2; a++) begin
      axis_dir[a]   = DIR_NONE;
      axis_start[a] = '0;
    end
  endfunction

  function void set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_STICK_THR: stick_thr = v[STICK_THR_W-1:0];
      REG_RATE_THR:  rate_thr  = v[RATE_THR_W-1:0];
      REG_HOLD_TIME: hold_us   = v[HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  // one axis; zero stick counts as a negative command
  function logic axis_confirms(int a, logic signed [STICK_W-1:0] s,
                               logic signed [RATE_W-1:0] r, logic [TIME_W-1:0] now);
    dir_t d;
    int   mag;
    int   along;
    d     = (s > 0) ? DIR_POS : DIR_NEG;
    mag   = (s < 0) ? -int'(s) : int'(s);
    along = (d == DIR_POS) ? int'(r) : -int'(r);
    if (mag >= int'(stick_thr) && along >= int'(rate_thr)) begin
      if (axis_dir[a] != d) begin
        axis_dir[a]   = d;
        axis_start[a] = now;
      end
      return (now - axis_start[a]) >= 32'(hold_us);
    end
    axis_dir[a]   = DIR_NONE;
    axis_start[a] = '0;
    return 1'b0;
  endfunction

  function void note_tick(in_item_t t);
    logic ev_roll;
    logic ev_pitch;
    logic ev;
    ev = 1'b0;
    if (!t.armed) begin
      flying = 1'b0;
      clear_axes();
    end else if (!flying) begin
      if (t.rescue_active) begin
        ev = 1'b1;
      end else if (t.link_ok) begin
        ev_roll  = axis_confirms(0, t.roll_stick, t.roll_rate, t.now_us);
        ev_pitch = axis_confirms(1, t.pitch_stick, t.pitch_rate, t.now_us);
        ev       = ev_roll | ev_pitch;
      end else begin
        clear_axes();
      end
      if (ev) begin
        flying = 1'b1;
        clear_axes();
      end
    end
    expected_q.push_back('{airborne: flying, evidence: ev});
  endfunction

  function void check_result(logic airborne, logic evidence);
    flight_verdict_t exp_v;
    if (expected_q.size() == 0) begin
      $error("unexpected result: is_airborne %0d evidence_now %0d", airborne, evidence);
      failures++;
      return;
    end
    exp_v = expected_q.pop_front();
    if (airborne !== exp_v.airborne) begin
      $error("is_airborne: expected %0d, got %0d", exp_v.airborne, airborne);
      failures++;
    end
    if (evidence !== exp_v.evidence) begin
      $error("evidence_now: expected %0d, got %0d", exp_v.evidence, evidence);
      failures++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_takeoff_evidence_latch_unit;
  import tel_pkg::*;

  // generous bound on the whole run: every tick plus the register writes
  localparam int unsigned CYCLE_LIMIT = 300000;
  // cycles to let the two-stage pipe settle before a register write / at end
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned TICKS_PER_PHASE = 80;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tel_in_if  in_ch ();
  tel_out_if out_ch ();

  airborne_scoreboard sb;

  // stimulus state
  bit                in_burst;   // sender never idles while set
  bit                out_burst;  // receiver never stalls while set
  logic [TIME_W-1:0] clock_us;   // running microsecond timestamp for episodes
  int unsigned       ticks_sent;
  int unsigned       cycles;

  takeoff_evidence_latch_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[takeoff_evidence_latch_unit] ERROR");
      $finish;
    end
  end

  // Monitors sample at the rising edge; all drivers use nonblocking updates,
  // so both sides see the values that were present before the edge.
  always @(posedge clk) begin : watch_in
    in_item_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.roll_stick    = in_ch.roll_stick;
      seen.pitch_stick   = in_ch.pitch_stick;
      seen.roll_rate     = in_ch.roll_rate;
      seen.pitch_rate    = in_ch.pitch_rate;
      seen.now_us        = in_ch.now_us;
      seen.armed         = in_ch.armed;
      seen.rescue_active = in_ch.rescue_active;
      seen.link_ok       = in_ch.link_ok;
      sb.note_tick(seen);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.is_airborne, out_ch.evidence_now);
  end

  // Receiver: holds ready low for a random stall before taking each result; no stall while out_burst is set.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(3, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One tick on in_ch. Valid is left high after the transfer so that
  // back-to-back ticks never see it dropped and raised in one step.
  task automatic send_tick(input in_item_t t);
    int gap;
    gap = in_burst ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.roll_stick    <= t.roll_stick;
    in_ch.pitch_stick   <= t.pitch_stick;
    in_ch.roll_rate     <= t.roll_rate;
    in_ch.pitch_rate    <= t.pitch_rate;
    in_ch.now_us        <= t.now_us;
    in_ch.armed         <= t.armed;
    in_ch.rescue_active <= t.rescue_active;
    in_ch.link_ok       <= t.link_ok;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  // APB write: setup phase, then access phase, then back to idle; pready is tied high.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_register(idx, v);
    @(posedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the pipe settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned stick, input int unsigned rate,
                           input int unsigned hold);
    drain();
    write_reg(REG_STICK_THR, CFG_DATA_W'(stick));
    write_reg(REG_RATE_THR, CFG_DATA_W'(rate));
    write_reg(REG_HOLD_TIME, CFG_DATA_W'(hold));
  endtask

  function automatic in_item_t make_tick(int rs, int ps, int rr, int pr,
                                         logic [TIME_W-1:0] now,
                                         bit arm, bit resc, bit lnk);
    in_item_t t;
    t.roll_stick    = STICK_W'(rs);
    t.pitch_stick   = STICK_W'(ps);
    t.roll_rate     = RATE_W'(rr);
    t.pitch_rate    = RATE_W'(pr);
    t.now_us        = now;
    t.armed         = arm;
    t.rescue_active = resc;
    t.link_ok       = lnk;
    return t;
  endfunction

  function automatic in_item_t noise_tick();
    return make_tick(int'($urandom()), int'($urandom()), int'($urandom()),
                     int'($urandom()), TIME_W'($urandom()), 1'($urandom()),
                     1'($urandom()), 1'($urandom()));
  endfunction

  // Takeoff attempt: a disarm to land, then armed ticks that mostly hold
  // one stick direction with matching rotation while time runs on in steps
  // of a fraction of the hold time. Rare flips, link drops and rescue.
  task automatic run_episode();
    int          len;
    int          axis;
    bit          neg;
    int          mag;
    int          along;
    int unsigned step;
    in_item_t    t;
    len  = $urandom_range(12, 3);
    axis = $urandom_range(1, 0);
    neg  = 1'($urandom());
    t = noise_tick();
    t.armed = 1'b0;
    send_tick(t);
    case ($urandom_range(3, 0))
      0: clock_us = 32'hFFFF_FFFF - TIME_W'($urandom_range(3 * 32'(sb.hold_us) + 10, 0));
      1: clock_us = TIME_W'($urandom());
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      step = 32'(sb.hold_us) / $urandom_range(4, 2) + $urandom_range(3, 0);
      if ($urandom_range(24, 0) == 0)
        step = $urandom();
      clock_us += step;
      if ($urandom_range(9, 0) == 0)
        neg = ~neg;
      mag = ($urandom_range(7, 0) == 0) ? $urandom_range(int'(sb.stick_thr), 0)
                                        : $urandom_range(1023, int'(sb.stick_thr));
      along = ($urandom_range(7, 0) == 0) ? $urandom_range(int'(sb.rate_thr), 0)
                                          : $urandom_range(32767, int'(sb.rate_thr));
      t = noise_tick();
      t.now_us        = clock_us;
      t.armed         = ($urandom_range(19, 0) != 0);
      t.rescue_active = ($urandom_range(19, 0) == 0);
      t.link_ok       = ($urandom_range(14, 0) != 0);
      if (axis == 0) begin
        t.roll_stick = STICK_W'(neg ? -mag : mag);
        t.roll_rate  = RATE_W'(neg ? -along : along);
      end else begin
        t.pitch_stick = STICK_W'(neg ? -mag : mag);
        t.pitch_rate  = RATE_W'(neg ? -along : along);
      end
      send_tick(t);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned stick;
    int unsigned rate;
    int unsigned hold;

    sb         = new();
    ticks_sent = 0;
    cycles     = 0;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    clock_us   = '0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.roll_stick    <= '0;
    in_ch.pitch_stick   <= '0;
    in_ch.roll_rate     <= '0;
    in_ch.pitch_rate    <= '0;
    in_ch.now_us        <= '0;
    in_ch.armed         <= 1'b0;
    in_ch.rescue_active <= 1'b0;
    in_ch.link_ok       <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset thresholds 100 / 150 / 250000 ----
    // disarmed with every field at its top value
    send_tick(make_tick(1023, 1023, 32767, 32767, 32'hFFFF_FFFF, 0, 1, 1));
    // roll response starts just below the timestamp wrap, confirms across it
    send_tick(make_tick(1023, 0, 32767, 0, 32'hFFFF_0000, 1, 0, 1));
    send_tick(make_tick(1023, 0, 32767, 0, 32'hFFFF_0000 + 250000, 1, 0, 1));
    // airborne stays latched, nothing evaluated; most negative fields
    send_tick(make_tick(-1024, -1024, -32768, -32768, 0, 1, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    // rescue confirms at once, even with the link down
    send_tick(make_tick(0, 0, 0, 0, 5, 1, 1, 0));
    send_tick(make_tick(0, 0, 0, 0, 6, 0, 0, 0));
    // pitch: full negative stick, most negative rate -> along is +32768
    send_tick(make_tick(0, -1024, 0, -32768, 100, 1, 0, 1));
    // direction flip restarts the timer, one tick short, then exact hold
    send_tick(make_tick(0, 500, 0, 300, 300100, 1, 0, 1));
    send_tick(make_tick(0, 500, 0, 300, 550099, 1, 0, 1));
    send_tick(make_tick(0, 500, 0, 300, 550100, 1, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    // exactly at both thresholds; link loss clears the timers
    send_tick(make_tick(100, 0, 150, 0, 1000, 1, 0, 1));
    send_tick(make_tick(100, 0, 150, 0, 500000, 1, 0, 0));
    send_tick(make_tick(100, 0, 150, 0, 600000, 1, 0, 1));
    send_tick(make_tick(-100, 0, -150, 0, 700000, 1, 0, 1));
    // mismatch, stick one short, rate one short
    send_tick(make_tick(-100, 0, 150, 0, 800000, 1, 0, 1));
    send_tick(make_tick(99, 0, 150, 0, 1100000, 1, 0, 1));
    send_tick(make_tick(100, 0, 149, 0, 1400000, 1, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));

    // ---- directed, all thresholds zero: zero stick reads as negative ----
    configure(0, 0, 0);
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 1, 10, 1, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 20, 1, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 30, 0, 0, 0));

    // ---- random phases: extremes first, then mixed settings ----
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          stick = 1023;
          rate  = 32767;
          hold  = 24'hFF_FFFF;
        end
        1: begin
          stick = 0;
          rate  = 0;
          hold  = 0;
        end
        2: begin
          stick = 100;
          rate  = 150;
          hold  = 250000;
        end
        default: begin
          stick = ($urandom_range(4, 0) == 0) ? 1023 : $urandom_range(1000, 0);
          rate  = $urandom_range(1, 0) ? $urandom_range(32767, 0) : $urandom_range(2000, 0);
          hold  = $urandom_range(1, 0) ? $urandom_range(1000, 0) : 32'(HOLD_W'($urandom()));
        end
      endcase
      configure(stick, rate, hold);
      // some phases run at full rate on one or both sides
      in_burst  = ($urandom_range(3, 0) == 0);
      out_burst = ($urandom_range(3, 0) == 0);
      target = ticks_sent + TICKS_PER_PHASE;
      while (ticks_sent < target) begin
        if ($urandom_range(3, 0) != 0)
          run_episode();
        else
          send_tick(noise_tick());
      end
    end

    drain();
    if (sb.failures == 0)
      $display("[takeoff_evidence_latch_unit] OK");
    else
      $display("[takeoff_evidence_latch_unit] ERROR");
    $finish;
  end

endmodule
